// ----- design/lphi_pkg.sv -----
// Shared types and constants for the linear-probe hash insert block.
package lphi_pkg;

    // Fixed field widths
    localparam int unsigned LPHI_KEY_W       = 32;
    localparam int unsigned LPHI_SLOT_W      = 10;
    localparam int unsigned LPHI_LIMIT_W     = 11;

    // Default table geometry and register reset value
    localparam int unsigned LPHI_TABLE_DEPTH = 1024;
    localparam logic [LPHI_LIMIT_W-1:0] LPHI_LIMIT_RESET = LPHI_LIMIT_W'(16);

    // Controller to datapath commands
    typedef struct packed {
        logic load;           // latch a new request, read its home slot
        logic advance;        // step to the next slot and read it
        logic store;          // write the key into the current slot
        logic emit_placed;    // present a placed result
        logic emit_conflict;  // present a conflict result
        logic clear_write;    // zero one table entry during the clear pass
    } lphi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic left_zero;      // probe budget used up
        logic slot_empty;     // slot just read holds zero
        logic clear_last;     // clear pass is on its last entry
    } lphi_status_t;

endpackage

// ----- design/lphi_ctrl.sv -----
// Controller state machine for the linear-probe hash insert block.
module lphi_ctrl
    import lphi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  lphi_status_t status,
    output lphi_cmd_t    cmd,
    output logic         busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.left_zero)
                begin
                    cmd.emit_conflict = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (status.slot_empty)
                begin
                    cmd.store       = 1'b1;
                    cmd.emit_placed = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clear pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- design/lphi_datapath.sv -----
// Datapath for the linear-probe hash insert block: table memory, probe state, results.
module lphi_datapath
    import lphi_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = LPHI_TABLE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lphi_cmd_t               cmd,
    output lphi_status_t            status,
    input  logic [LPHI_KEY_W-1:0]   key,
    input  logic                    cfg_wr_en,
    input  logic [LPHI_LIMIT_W-1:0] cfg_wr_data,
    output logic                    done,
    output logic                    placed,
    output logic [LPHI_SLOT_W-1:0]  slot,
    output logic [LPHI_KEY_W-1:0]   key_out
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned WIDE_W = (ADDR_W > LPHI_SLOT_W) ? ADDR_W : LPHI_SLOT_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    logic [LPHI_KEY_W-1:0]   slot_table [TABLE_DEPTH];

    logic [LPHI_LIMIT_W-1:0] probe_limit_reg;
    logic [LPHI_KEY_W-1:0]   key_reg;
    logic [ADDR_W-1:0]       pos_reg;
    logic [ADDR_W-1:0]       pos_next;
    logic [LPHI_LIMIT_W-1:0] left_reg;
    logic [LPHI_LIMIT_W-1:0] left_next;
    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic [LPHI_KEY_W-1:0]   rd_data_reg;
    logic                    done_reg;
    logic                    placed_reg;
    logic [LPHI_SLOT_W-1:0]  slot_reg;
    logic [LPHI_KEY_W-1:0]   key_out_reg;

    logic                    rd_en;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [LPHI_KEY_W-1:0]   wr_data;
    logic [WIDE_W-1:0]       pos_wide;

    // Probe address: home slot on load, next slot (wrapping) on advance
    always_comb
    begin
        pos_next  = pos_reg;
        left_next = left_reg;
        if (cmd.load)
        begin
            pos_next  = key[ADDR_W-1:0];
            left_next = probe_limit_reg;
        end
        else if (cmd.advance)
        begin
            pos_next  = pos_reg + 1'b1;
            left_next = left_reg - 1'b1;
        end
    end

    assign rd_en = cmd.load | cmd.advance;

    // Write port: clear pass or key store
    always_comb
    begin
        if (cmd.clear_write)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = cmd.store;
            wr_addr = pos_reg;
            wr_data = key_reg;
        end
    end

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_table[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_table[pos_next];
        end
    end

    // Probe payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key;
        end
        pos_reg <= pos_next;
    end

    // Budget counter, clear counter and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg        <= '0;
            clr_cnt_reg     <= '0;
            probe_limit_reg <= LPHI_LIMIT_RESET;
        end
        else
        begin
            left_reg <= left_next;
            if (cmd.clear_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                probe_limit_reg <= cfg_wr_data;
            end
        end
    end

    assign status.left_zero  = (left_reg == '0);
    assign status.slot_empty = (rd_data_reg == '0);
    assign status.clear_last = (clr_cnt_reg == LAST_ADDR);

    // Result slot keeps the low slot bits of the position
    assign pos_wide = WIDE_W'(pos_reg);

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_placed | cmd.emit_conflict;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_placed | cmd.emit_conflict)
        begin
            placed_reg  <= cmd.emit_placed;
            slot_reg    <= cmd.emit_placed ? pos_wide[LPHI_SLOT_W-1:0] : '0;
            key_out_reg <= key_reg;
        end
    end

    assign done    = done_reg;
    assign placed  = placed_reg;
    assign slot    = slot_reg;
    assign key_out = key_out_reg;

    // A key is only stored into a slot that read back empty
    a_store_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> status.slot_empty)
        else $error("store into occupied slot");

    // Never probe past the budget
    a_advance_budget: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> !status.left_zero)
        else $error("probe beyond budget");

    // A request always passes through the check state before its result, so results never come back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("back to back results");

    // Budget is loaded from the limit register on accept
    a_budget_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (left_reg == $past(probe_limit_reg)))
        else $error("budget not loaded");

endmodule

// ----- design/linear_probe_hash_insert_top.sv -----
// Top level of the linear-probe hash insert block.
//
// Inserts 32-bit keys into an open-addressed table by linear probing.
// Request channel: a key is taken at a clock edge where start is high and
// busy is low. Each request gives exactly one result: done is high for one
// cycle with placed, slot and key_out; the receiver cannot stall it.
// Timing: the first probe reads the home slot in the accept cycle; each
// further probe reads the next slot, wrapping, through the table's read
// port. With budget L, a conflict is returned once L probed slots read
// back occupied. busy drops in the cycle done is shown, so a new request
// is taken only once the previous result is shown.
// probe_limit must be written through cfg_wr_en/cfg_wr_data while idle;
// the block does not enforce this. Reset: probe_limit returns to 16 and
// the table is cleared to zero by a pass that writes one entry a cycle,
// with busy high; config writes are still taken during the pass.
module linear_probe_hash_insert_top
    import lphi_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = LPHI_TABLE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [LPHI_KEY_W-1:0]   key,
    input  logic                    cfg_wr_en,
    input  logic [LPHI_LIMIT_W-1:0] cfg_wr_data,
    output logic                    done,
    output logic                    placed,
    output logic [LPHI_SLOT_W-1:0]  slot,
    output logic [LPHI_KEY_W-1:0]   key_out
);

    lphi_cmd_t    cmd;
    lphi_status_t status;

    lphi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lphi_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .key         (key),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .placed      (placed),
        .slot        (slot),
        .key_out     (key_out)
    );

endmodule
